### design/bse_pkg.sv
// shared types, constants and header byte table for the bmp24 stream encoder
// no dependencies
package bse_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int CNT_W      = 12;
    localparam int HDR_LEN    = 54;
    localparam int HDR_IDX_W  = 6;
    localparam int ROWB_W     = 14;
    localparam int DATA_W     = 27;
    localparam int FILE_W     = 28;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [7:0] PIXEL_OFFSET = 8'd54;
    localparam logic [7:0] INFO_LEN     = 8'd40;
    localparam logic [7:0] BITS_PER_PX  = 8'd24;
    localparam logic [7:0] PPM_LO       = 8'h13;
    localparam logic [7:0] PPM_HI       = 8'h0B;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       image_end;
    } result_t;

    typedef struct packed {
        pixel_t     px;
        logic       hdr;
        logic [1:0] pad;
        logic       img_end;
    } entry_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_HDR,
        PH_BLUE,
        PH_GREEN,
        PH_RED,
        PH_PAD
    } phase_t;

    function automatic logic [7:0] hdr_byte(
        input logic [HDR_IDX_W-1:0] idx,
        input logic [DIM_W-1:0]     w,
        input logic [DIM_W-1:0]     h,
        input logic [FILE_W-1:0]    file_len,
        input logic [DATA_W-1:0]    data_len
    );
        logic [7:0] b;
        b = 8'd0;
        case (idx)
            6'd0:    b = 8'h42;
            6'd1:    b = 8'h4D;
            6'd2:    b = file_len[7:0];
            6'd3:    b = file_len[15:8];
            6'd4:    b = file_len[23:16];
            6'd5:    b = {4'd0, file_len[27:24]};
            6'd10:   b = PIXEL_OFFSET;
            6'd14:   b = INFO_LEN;
            6'd18:   b = w[7:0];
            6'd19:   b = {3'd0, w[12:8]};
            6'd22:   b = h[7:0];
            6'd23:   b = {3'd0, h[12:8]};
            6'd26:   b = 8'd1;
            6'd28:   b = BITS_PER_PX;
            6'd34:   b = data_len[7:0];
            6'd35:   b = data_len[15:8];
            6'd36:   b = data_len[23:16];
            6'd37:   b = {5'd0, data_len[26:24]};
            6'd38:   b = PPM_LO;
            6'd39:   b = PPM_HI;
            6'd42:   b = PPM_LO;
            6'd43:   b = PPM_HI;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

### design/bse_front.sv
// front end: accepts pixels and tags each with header, padding and image end
// depends on bse_pkg
module bse_front
    import bse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] width_eff,
    input  logic [DIM_W-1:0] height_eff,
    input  pixel_t           pixel,
    input  logic             pixel_valid,
    output logic             pixel_ready,
    input  logic             q_full,
    output logic             q_push,
    output entry_t           q_entry
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             hdr_sent_reg, hdr_sent_next;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             row_end, img_end;

    assign pixel_ready = !q_full;
    assign q_push      = pixel_valid && pixel_ready;

    always_comb
    begin
        col_inc = {1'b0, col_reg} + {{(DIM_W-1){1'b0}}, 1'b1};
        row_inc = {1'b0, row_reg} + {{(DIM_W-1){1'b0}}, 1'b1};
        row_end = col_inc >= width_eff;
        img_end = row_end && (row_inc >= height_eff);

        q_entry.px      = pixel;
        q_entry.hdr     = !hdr_sent_reg;
        q_entry.pad     = row_end ? width_eff[1:0] : 2'd0;
        q_entry.img_end = img_end;

        col_next      = col_reg;
        row_next      = row_reg;
        hdr_sent_next = hdr_sent_reg;
        if (q_push)
        begin
            hdr_sent_next = 1'b1;
            if (row_end)
            begin
                col_next = '0;
                if (img_end)
                begin
                    row_next      = '0;
                    hdr_sent_next = 1'b0;
                end
                else
                begin
                    row_next = row_inc[CNT_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            hdr_sent_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            hdr_sent_reg <= hdr_sent_next;
        end
    end

endmodule

### design/bse_fifo.sv
// short queue of tagged pixels between front and back
// depends on bse_pkg
module bse_fifo
    import bse_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   full,
    output logic   empty
);

    entry_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full  = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (FIFO_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

### design/bse_back.sv
// back end: byte sequencer for header, pixel and padding bytes, output register
// depends on bse_pkg
module bse_back
    import bse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] width_eff,
    input  logic [DIM_W-1:0] height_eff,
    input  entry_t           head,
    input  logic             q_empty,
    output logic             q_pop,
    output result_t          result,
    output logic             result_valid,
    input  logic             result_ready
);

    logic [ROWB_W-1:0]    row_bytes_reg;
    logic [DATA_W-1:0]    data_len_reg;
    logic [FILE_W-1:0]    file_len_reg;
    phase_t               phase_reg, phase_next, cur_phase;
    logic [HDR_IDX_W-1:0] idx_reg, idx_next;
    result_t              result_reg, result_next;
    logic                 valid_reg;
    logic                 load, last;
    logic [7:0]           byte_val;

    // file size arithmetic, one step per cycle
    always_ff @(posedge clk)
    begin
        row_bytes_reg <= ({1'b0, width_eff} << 1) + ROWB_W'(width_eff)
                         + ROWB_W'(width_eff[1:0]);
        data_len_reg  <= DATA_W'(row_bytes_reg) * DATA_W'(height_eff);
        file_len_reg  <= FILE_W'(data_len_reg) + FILE_W'(HDR_LEN);
    end

    assign load = !q_empty && (!valid_reg || result_ready);

    always_comb
    begin
        if (phase_reg == PH_START)
            cur_phase = head.hdr ? PH_HDR : PH_BLUE;
        else
            cur_phase = phase_reg;

        byte_val   = 8'd0;
        last       = 1'b0;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        case (cur_phase)
            PH_HDR:
            begin
                byte_val = hdr_byte(idx_reg, width_eff, height_eff,
                                    file_len_reg, data_len_reg);
                if (idx_reg == HDR_IDX_W'(HDR_LEN - 1))
                begin
                    phase_next = PH_BLUE;
                    idx_next   = '0;
                end
                else
                begin
                    phase_next = PH_HDR;
                    idx_next   = idx_reg + HDR_IDX_W'(1);
                end
            end
            PH_BLUE:
            begin
                byte_val   = head.px.blue;
                phase_next = PH_GREEN;
            end
            PH_GREEN:
            begin
                byte_val   = head.px.green;
                phase_next = PH_RED;
            end
            PH_RED:
            begin
                byte_val = head.px.red;
                if (head.pad == 2'd0)
                begin
                    last       = 1'b1;
                    phase_next = PH_START;
                end
                else
                begin
                    phase_next = PH_PAD;
                    idx_next   = '0;
                end
            end
            PH_PAD:
            begin
                byte_val = 8'd0;
                if (idx_reg[1:0] == head.pad - 2'd1)
                begin
                    last       = 1'b1;
                    phase_next = PH_START;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + HDR_IDX_W'(1);
                end
            end
            default:
            begin
                phase_next = PH_START;
                idx_next   = '0;
            end
        endcase

        result_next.out_byte  = byte_val;
        result_next.run_end   = last;
        result_next.image_end = last && head.img_end;
    end

    assign q_pop        = load && last;
    assign result       = result_reg;
    assign result_valid = valid_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    a_image_end_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.image_end |-> result.run_end)
        else $error("image end without run end");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    a_pad_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAD && !q_empty |-> head.pad != 2'd0 && idx_reg[1:0] < head.pad)
        else $error("padding index out of range");

    a_start_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_START |-> idx_reg == '0)
        else $error("byte index not cleared between pixels");

endmodule

### design/bmp24_stream_encoder.sv
// bmp24 stream encoder top level: config registers, front end, queue, back end
// depends on bse_pkg, bse_front, bse_fifo, bse_back
// a pixel beat is stored in the queue; its bytes then leave via the output register
// bytes: 3 per pixel, plus 54 header bytes before the first pixel of an image and
// width mod 4 padding bytes per row, all sent through the one-byte output register
// reset: asynchronous active low; width and height return to 1, header pending
module bmp24_stream_encoder
    import bse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  pixel_t               pixel,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    output result_t              result,
    output logic                 result_valid,
    input  logic                 result_ready
);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] width_eff, height_eff;
    logic             q_full, q_empty, q_push, q_pop;
    entry_t           q_entry, q_head;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    assign cfg_ready  = 1'b1;
    assign width_eff  = clamp_dim(width_reg);
    assign height_eff = clamp_dim(height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    bse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .width_eff   (width_eff),
        .height_eff  (height_eff),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    bse_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    bse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .width_eff    (width_eff),
        .height_eff   (height_eff),
        .head         (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

### sim/tb.sv
// testbench for bmp24_stream_encoder: a directed table of pixels and register writes, then
// random whole and broken images; each byte checked against the table or in-bench encoder
// depends on bse_pkg and the encoder rtl
module tb;
    import bse_pkg::*;

    localparam int PLAN_LEN      = 43;
    localparam int RANDOM_PIXELS = 460;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [31:0] PX_PER_METRE = 32'd2835;

    typedef enum logic {
        STEP_PIXEL,
        STEP_REG
    } step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]     val;
        pixel_t               px;
        logic                 typed;
        logic [1:0]           pad;
        logic                 closes;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    pixel_t               pixel;
    logic                 pixel_valid;
    logic                 pixel_ready;
    result_t              result;
    logic                 result_valid;
    logic                 result_ready = 1'b0;

    result_t     expected_bytes[$];
    result_t     want_byte;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    int          column;
    int          row;
    bit          hdr_owed;
    bit          tx_calm;
    bit          rx_calm;
    int          rx_hold;
    int          errors;
    int          pixels_sent;
    int          bytes_seen;
    int          files_seen;
    int          reg_writes;
    int unsigned cycles = 0;

    // directed table; pixel literals are red, green, blue
    plan_row_t plan [0:PLAN_LEN-1] = '{
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hffffff, 1'b0, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_HEIGHT, 13'd0,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h8001fe, 1'b0, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd3,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_HEIGHT, 13'd2,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'ha55ac3, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h5aa53c, 1'b1, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h123456, 1'b1, 2'd3, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hff00ff, 1'b1, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h00ff00, 1'b1, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h7f8001, 1'b1, 2'd3, 1'b1},
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd2,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_HEIGHT, 13'd1,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h010204, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h081020, 1'b1, 2'd2, 1'b1},
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd5,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h4080ff, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hc0c0c0, 1'b1, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h0f0f0f, 1'b1, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hf0f0f0, 1'b1, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h336699, 1'b1, 2'd1, 1'b1},
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd8191, 24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_HEIGHT, 13'd8191, 24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hffffff, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b1, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd2,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h55aa55, 1'b1, 2'd2, 1'b0},
        '{STEP_REG,   REG_IMAGE_HEIGHT, 13'd1,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'haa55aa, 1'b1, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h804020, 1'b1, 2'd2, 1'b1},
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd4096, 24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_HEIGHT, 13'd4096, 24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h102030, 1'b0, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd1,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_REG,   REG_IMAGE_HEIGHT, 13'd1,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hfe01fe, 1'b1, 2'd1, 1'b1},
        '{STEP_REG,   REG_IMAGE_WIDTH,  13'd4,    24'h000000, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h01fe01, 1'b0, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b1, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hffffff, 1'b1, 2'd0, 1'b0},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h9c9c9c, 1'b1, 2'd0, 1'b1}
    };

    bmp24_stream_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel        (pixel),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    always #4 clk = ~clk;

    function automatic int dim_in_use(input logic [12:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // advances the encoder state for one pixel; queues its bytes when asked
    function automatic void encode_pixel(input pixel_t px, input bit keep);
        logic [7:0]  seq [0:59];
        logic [31:0] w32;
        logic [31:0] h32;
        logic [31:0] data32;
        logic [31:0] file32;
        int          w;
        int          h;
        int          n;
        bit          closes;
        w = dim_in_use(width_reg);
        h = dim_in_use(height_reg);
        n = 0;
        closes = 1'b0;
        if (hdr_owed)
        begin
            w32 = w;
            h32 = h;
            data32 = (32'd3 * w32 + (w32 & 32'd3)) * h32;
            file32 = data32 + 32'd54;
            for (int k = 0; k < 54; k++)
            begin
                seq[k] = 8'h00;
            end
            seq[0] = 8'h42;
            seq[1] = 8'h4d;
            for (int k = 0; k < 4; k++)
            begin
                seq[2 + k]  = file32[8*k +: 8];
                seq[18 + k] = w32[8*k +: 8];
                seq[22 + k] = h32[8*k +: 8];
                seq[34 + k] = data32[8*k +: 8];
                seq[38 + k] = PX_PER_METRE[8*k +: 8];
                seq[42 + k] = PX_PER_METRE[8*k +: 8];
            end
            seq[10] = 8'd54;
            seq[14] = 8'd40;
            seq[26] = 8'd1;
            seq[28] = 8'd24;
            n = 54;
            hdr_owed = 1'b0;
        end
        seq[n]     = px.blue;
        seq[n + 1] = px.green;
        seq[n + 2] = px.red;
        n = n + 3;
        if (column + 1 >= w)
        begin
            for (int k = 0; k < (w % 4); k++)
            begin
                seq[n] = 8'h00;
                n++;
            end
            column = 0;
            if (row + 1 >= h)
            begin
                row = 0;
                hdr_owed = 1'b1;
                closes = 1'b1;
            end
            else
            begin
                row++;
            end
        end
        else
        begin
            column++;
        end
        if (keep)
        begin
            for (int k = 0; k < n; k++)
            begin
                expected_bytes.push_back('{seq[k], k == n - 1, closes && (k == n - 1)});
            end
        end
    endfunction

    // pixel bytes and row padding as typed in the table
    function automatic void push_plain(input pixel_t px, input logic [1:0] pad, input bit closes);
        logic [7:0] seq [0:5];
        int         n;
        seq[0] = px.blue;
        seq[1] = px.green;
        seq[2] = px.red;
        n = 3;
        for (int k = 0; k < pad; k++)
        begin
            seq[n] = 8'h00;
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            expected_bytes.push_back('{seq[k], k == n - 1, closes && (k == n - 1)});
        end
    endfunction

    task automatic send_pixel(input pixel_t px, input bit typed, input logic [1:0] pad,
                              input bit closes);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel <= px;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (!pixel_ready) @(posedge clk);
        encode_pixel(px, !typed);
        if (typed)
        begin
            push_plain(px, pad, closes);
        end
        pixels_sent++;
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        drain();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
        begin
            width_reg = val;
        end
        else if (idx == REG_IMAGE_HEIGHT)
        begin
            height_reg = val;
        end
        reg_writes++;
    endtask

    // byte sink with random stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                bytes_seen++;
                if (result.image_end)
                begin
                    files_seen++;
                end
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: expected no beat, got byte %02h run_end %b image_end %b",
                             $time, result.out_byte, result.run_end, result.image_end);
                    errors++;
                end
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    if (result.out_byte !== want_byte.out_byte
                        || result.run_end !== want_byte.run_end
                        || result.image_end !== want_byte.image_end)
                    begin
                        $display("%0t: expected byte %02h run_end %b image_end %b, got %02h %b %b",
                                 $time, want_byte.out_byte, want_byte.run_end,
                                 want_byte.image_end, result.out_byte, result.run_end,
                                 result.image_end);
                        errors++;
                    end
                end
                rx_hold = rx_calm ? 0 : $urandom_range(0, 5);
                if (rx_hold != 0)
                begin
                    result_ready <= 1'b0;
                end
            end
            else if (!result_ready)
            begin
                if (rx_hold <= 1)
                begin
                    result_ready <= 1'b1;
                end
                rx_hold = rx_hold - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d bytes outstanding", $time, expected_bytes.size());
            $display("FAIL bmp24_stream_encoder");
            $finish;
        end
    end

    initial
    begin
        int     roll;
        int     burst;
        int     rand_sent;
        pixel_t rand_px;
        errors = 0;
        pixels_sent = 0;
        bytes_seen = 0;
        files_seen = 0;
        reg_writes = 0;
        rx_hold = 0;
        rand_sent = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        width_reg = 13'd1;
        height_reg = 13'd1;
        column = 0;
        row = 0;
        hdr_owed = 1'b1;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= '0;
        pixel <= '0;
        pixel_valid <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == STEP_REG)
            begin
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                send_pixel(plan[i].px, plan[i].typed, plan[i].pad, plan[i].closes);
            end
        end

        // mostly whole small images, some broken off or at odd sizes
        while (rand_sent < RANDOM_PIXELS)
        begin
            roll = $urandom_range(0, 9);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (roll == 0)
            begin
                write_reg(REG_IMAGE_WIDTH, DIM_W'($urandom));
                write_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom));
                burst = $urandom_range(1, 6);
            end
            else
            begin
                if (roll != 1)
                begin
                    write_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(1, 9)));
                end
                if (roll != 2)
                begin
                    write_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(1, 4)));
                end
                burst = dim_in_use(width_reg) * dim_in_use(height_reg);
                if (roll == 3 || burst > 40)
                begin
                    burst = $urandom_range(1, (burst > 40) ? 40 : burst);
                end
            end
            repeat (burst)
            begin
                rand_px = 24'($urandom);
                send_pixel(rand_px, 1'b0, 2'd0, 1'b0);
                rand_sent++;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
            errors++;
        end
        $display("%0d pixels sent, %0d bytes checked, %0d complete files, %0d register writes",
                 pixels_sent, bytes_seen, files_seen, reg_writes);
        $display("sizes ranged over zero, small, 4096 and oversize settings, some changed mid-image");
        if (errors == 0)
        begin
            $display("PASS bmp24_stream_encoder");
        end
        else
        begin
            $display("FAIL bmp24_stream_encoder");
        end
        $finish;
    end

endmodule
